// File: sv/rkpt_pkg.sv
// Shared types, codes and the watched key table for the repeated key press trigger.
package rkpt_pkg;

    localparam int NUM_WATCHED_KEYS_DEF  = 7;
    localparam int TICK_COUNTER_BITS_DEF = 16;
    localparam int MAX_WATCHED_KEYS      = 16;
    localparam int PADDR_W               = 4;

    // func codes of an input item
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_EVENT = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // held_status codes
    localparam logic [1:0] HELD_NONE   = 2'd0;
    localparam logic [1:0] HELD_SINGLE = 2'd1;

    localparam logic [1:0] EV_PRESS = 2'd1;

    // phase codes
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_WAIT  = 3'd1;
    localparam logic [2:0] PH_COUNT = 3'd2;
    localparam logic [2:0] PH_DONE  = 3'd3;
    localparam logic [2:0] PH_FAIL  = 3'd4;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_SKIP_DELAY  = 2'd0;
    localparam logic [1:0] REG_FIRST_WAIT  = 2'd1;
    localparam logic [1:0] REG_WINDOW      = 2'd2;
    localparam logic [1:0] REG_PRESSES     = 2'd3;

    localparam logic [15:0] FIRST_WAIT_RST = 16'd2000;
    localparam logic [15:0] WINDOW_RST     = 16'd5000;
    localparam logic [3:0]  PRESSES_RST    = 4'd5;

    // volume down, volume up, power, home, back, menu, camera; 1024 never matches
    localparam logic [10:0] WATCHED_KEYS [MAX_WATCHED_KEYS] = '{
        11'd114, 11'd115, 11'd116, 11'd102, 11'd158, 11'd139, 11'd212,
        11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024,
        11'd1024, 11'd1024, 11'd1024
    };

    typedef struct packed {
        logic [1:0] func;
        logic       devices_present;
        logic [1:0] held_status;
        logic [9:0] held_code;
        logic       is_key_event;
        logic [9:0] event_code;
        logic [1:0] event_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0] phase;
        logic [1:0] short_buzzes;
        logic       long_buzz;
        logic       decided;
        logic [3:0] presses_seen;
    } out_item_t;

    typedef struct packed {
        logic        skip_initial_delay;
        logic [15:0] first_wait_ticks;
        logic [15:0] count_window_ticks;
        logic [3:0]  presses_needed;
    } cfg_t;

    function automatic logic key_watched(logic [9:0] code, int nkeys);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < MAX_WATCHED_KEYS; i++)
        begin
            if (i < nkeys && WATCHED_KEYS[i] == {1'b0, code})
                hit = 1'b1;
        end
        return hit;
    endfunction

endpackage

// File: sv/rkpt_cfg.sv
// APB register file holding the trigger configuration.
module rkpt_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rkpt_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output rkpt_pkg::cfg_t                    cfg
);

    logic        skip_reg;
    logic [15:0] first_wait_reg;
    logic [15:0] window_reg;
    logic [3:0]  presses_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg       <= 1'b0;
            first_wait_reg <= rkpt_pkg::FIRST_WAIT_RST;
            window_reg     <= rkpt_pkg::WINDOW_RST;
            presses_reg    <= rkpt_pkg::PRESSES_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                rkpt_pkg::REG_SKIP_DELAY: skip_reg       <= pwdata[0];
                rkpt_pkg::REG_FIRST_WAIT: first_wait_reg <= pwdata[15:0];
                rkpt_pkg::REG_WINDOW:     window_reg     <= pwdata[15:0];
                rkpt_pkg::REG_PRESSES:    presses_reg    <= pwdata[3:0];
                default:                  skip_reg       <= skip_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            rkpt_pkg::REG_SKIP_DELAY: prdata = {31'd0, skip_reg};
            rkpt_pkg::REG_FIRST_WAIT: prdata = {16'd0, first_wait_reg};
            rkpt_pkg::REG_WINDOW:     prdata = {16'd0, window_reg};
            rkpt_pkg::REG_PRESSES:    prdata = {28'd0, presses_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    assign cfg.skip_initial_delay = skip_reg;
    assign cfg.first_wait_ticks   = first_wait_reg;
    assign cfg.count_window_ticks = window_reg;
    assign cfg.presses_needed     = presses_reg;

endmodule

// File: sv/rkpt_engine.sv
// Detection state and the one-item step rule.
module rkpt_engine #(
    parameter int NUM_WATCHED_KEYS  = rkpt_pkg::NUM_WATCHED_KEYS_DEF,
    parameter int TICK_COUNTER_BITS = rkpt_pkg::TICK_COUNTER_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rkpt_pkg::cfg_t       cfg,
    input  logic                 step,
    input  rkpt_pkg::in_item_t   item,
    output rkpt_pkg::out_item_t  result
);

    localparam logic [32:0] TICK_MAX = {1'b0, {32{1'b1}}} >> (32 - TICK_COUNTER_BITS);

    logic [2:0]                   mode_reg,  mode_next;
    logic [9:0]                   key_reg,   key_next;
    logic [3:0]                   press_reg, press_next;
    logic [TICK_COUNTER_BITS-1:0] ticks_reg, ticks_next;

    logic [TICK_COUNTER_BITS-1:0] first_lim, window_lim;
    logic [1:0]                   sb;
    logic                         lb, dec;
    logic                         held_watched, ev_watched, single;
    logic                         first_press;
    logic [9:0]                   first_code;

    function automatic logic [TICK_COUNTER_BITS-1:0] tick_limit(logic [15:0] v);
        logic [32:0] v33;
        logic [32:0] lim;
        v33 = {17'd0, v};
        lim = (v33 > TICK_MAX) ? TICK_MAX : v33;
        return lim[TICK_COUNTER_BITS-1:0];
    endfunction

    assign first_lim    = tick_limit(cfg.first_wait_ticks);
    assign window_lim   = tick_limit(cfg.count_window_ticks);
    assign held_watched = rkpt_pkg::key_watched(item.held_code, NUM_WATCHED_KEYS);
    assign ev_watched   = rkpt_pkg::key_watched(item.event_code, NUM_WATCHED_KEYS);
    assign single       = (item.held_status == rkpt_pkg::HELD_SINGLE) && held_watched;

    always_comb
    begin
        mode_next   = mode_reg;
        key_next    = key_reg;
        press_next  = press_reg;
        ticks_next  = ticks_reg;
        sb          = 2'd0;
        lb          = 1'b0;
        dec         = 1'b0;
        first_press = 1'b0;
        first_code  = item.held_code;

        case (item.func)
            rkpt_pkg::FUNC_START:
            begin
                press_next = 4'd0;
                key_next   = 10'd0;
                ticks_next = '0;
                if (!item.devices_present || item.held_status[1]
                    || (!single && cfg.skip_initial_delay))
                begin
                    mode_next = rkpt_pkg::PH_FAIL;
                    dec       = 1'b1;
                end
                else if (single)
                begin
                    first_press = 1'b1;
                end
                else
                begin
                    ticks_next = first_lim;
                    if (first_lim == '0)
                    begin
                        mode_next = rkpt_pkg::PH_FAIL;
                        dec       = 1'b1;
                    end
                    else
                        mode_next = rkpt_pkg::PH_WAIT;
                end
            end
            rkpt_pkg::FUNC_EVENT:
            begin
                if (item.is_key_event && item.event_value == rkpt_pkg::EV_PRESS
                    && ev_watched)
                begin
                    if (mode_reg == rkpt_pkg::PH_WAIT)
                    begin
                        first_press = 1'b1;
                        first_code  = item.event_code;
                    end
                    else if (mode_reg == rkpt_pkg::PH_COUNT)
                    begin
                        if (item.event_code == key_reg)
                        begin
                            if (press_reg != 4'hF)
                                press_next = press_reg + 4'd1;
                            if (press_next >= cfg.presses_needed)
                            begin
                                mode_next = rkpt_pkg::PH_DONE;
                                lb        = 1'b1;
                                dec       = 1'b1;
                            end
                            else
                                sb = 2'd1;
                        end
                        else
                        begin
                            mode_next = rkpt_pkg::PH_FAIL;
                            dec       = 1'b1;
                        end
                    end
                end
            end
            rkpt_pkg::FUNC_TICK:
            begin
                if (mode_reg == rkpt_pkg::PH_WAIT || mode_reg == rkpt_pkg::PH_COUNT)
                begin
                    if (ticks_reg != '0)
                        ticks_next = ticks_reg - TICK_COUNTER_BITS'(1);
                    if (ticks_next == '0)
                    begin
                        mode_next = rkpt_pkg::PH_FAIL;
                        dec       = 1'b1;
                    end
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        // first press of a sequence, from a held key at start or a press while waiting
        if (first_press)
        begin
            key_next   = first_code;
            press_next = 4'd1;
            ticks_next = window_lim;
            sb         = 2'd2;
            if (cfg.presses_needed <= 4'd1)
            begin
                mode_next = rkpt_pkg::PH_DONE;
                lb        = 1'b1;
                dec       = 1'b1;
            end
            else if (window_lim == '0)
            begin
                mode_next = rkpt_pkg::PH_FAIL;
                dec       = 1'b1;
            end
            else
                mode_next = rkpt_pkg::PH_COUNT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= rkpt_pkg::PH_IDLE;
            key_reg   <= 10'd0;
            press_reg <= 4'd0;
            ticks_reg <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            key_reg   <= key_next;
            press_reg <= press_next;
            ticks_reg <= ticks_next;
        end
    end

    assign result.phase        = mode_next;
    assign result.short_buzzes = sb;
    assign result.long_buzz    = lb;
    assign result.decided      = dec;
    assign result.presses_seen = press_next;

endmodule

// File: sv/repeated_key_press_trigger_top.sv
// Repeated key press trigger: input register, step engine, result register.
// Order: an accepted item loads the input register, and the result register then loads
//   from the engine once the output side does not stall.
// Throughput: one item per cycle when the output side does not stall; while a result
//   waits under a stall the input register takes one more item, then stalls the input.
// Reset: rst_n clears the phase to idle, counters, key and valid flags, and loads
//   the configuration registers with their defaults.
module repeated_key_press_trigger_top #(
    parameter int NUM_WATCHED_KEYS  = rkpt_pkg::NUM_WATCHED_KEYS_DEF,
    parameter int TICK_COUNTER_BITS = rkpt_pkg::TICK_COUNTER_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  rkpt_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output rkpt_pkg::out_item_t           out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rkpt_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    rkpt_pkg::cfg_t      cfg;
    rkpt_pkg::in_item_t  in_item_reg;
    rkpt_pkg::out_item_t out_item_reg;
    rkpt_pkg::out_item_t result;
    logic                in_full_reg, in_full_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free, fire, accept;

    rkpt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rkpt_engine #(
        .NUM_WATCHED_KEYS  (NUM_WATCHED_KEYS),
        .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (fire),
        .item   (in_item_reg),
        .result (result)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = in_full_reg && out_free;
    assign in_stall = in_full_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    assign in_full_next   = accept | (in_full_reg & ~fire);
    assign out_valid_next = fire | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= in_data;
        if (fire)
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule
